>>> rtl/core/adc_jitter_min_max_monitor_assert.svh
// Assertion macros for the jitter monitor.
`ifndef ADC_JITTER_MIN_MAX_MONITOR_ASSERT_SVH
`define ADC_JITTER_MIN_MAX_MONITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AJM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define AJM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ajm_pkg.sv
`default_nettype none

package ajm_pkg;

   // Parameter defaults
   localparam int NUM_MODULES_DEF     = 2;
   localparam int PINS_PER_MODULE_DEF = 64;
   localparam int GROUP_SIZE_DEF      = 8;

   localparam int SAMPLE_W   = 12;
   localparam int PIN_W      = 6;
   localparam int CTRL_W     = 7;
   localparam int CSR_DATA_W = 16;
   localparam int PERIOD_W   = 16;

   localparam logic [CTRL_W-1:0] CTRL_OFFSET = 7'h10;
   localparam int                CTRL_SHIFT  = 5;

   localparam logic             SEND_CTRL_RST = 1'b0;
   localparam logic [1:0]       WATCH_MOD_RST = 2'd1;
   localparam logic [3:0]       WATCH_GRP_RST = 4'd1;
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

   typedef enum logic [1:0] {
      CSR_SEND_CTRL = 2'd0,
      CSR_WATCH_MOD = 2'd1,
      CSR_WATCH_GRP = 2'd2,
      CSR_PERIOD    = 2'd3
   } csr_index_type;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic KIND_CTRL   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic                command;
      logic                module_index;
      logic [PIN_W-1:0]    pin_index;
      logic [SAMPLE_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [CTRL_W-1:0]   controller_number;
      logic [CTRL_W-1:0]   controller_value;
      logic [PIN_W-1:0]    report_pin;
      logic [SAMPLE_W-1:0] min_value;
      logic [SAMPLE_W-1:0] max_value;
      logic [SAMPLE_W-1:0] spread;
      logic                min_seen;
      logic                max_seen;
      logic                spread_valid;
      logic                last_of_report;
   } rsp_type;

   // One channel entry; min_none stands for the cleared minimum.
   typedef struct packed {
      logic                min_none;
      logic [SAMPLE_W-1:0] min_value;
      logic [SAMPLE_W-1:0] max_value;
   } entry_type;

   localparam entry_type ENTRY_CLEAR = '{min_none: 1'b1, min_value: '0, max_value: '0};

endpackage

`default_nettype wire

>>> rtl/core/ajm_store.sv
`default_nettype none

// Channel min/max memory: one write port, one registered read port.
module ajm_store #(
   parameter int DEPTH  = ajm_pkg::NUM_MODULES_DEF * ajm_pkg::PINS_PER_MODULE_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire                 clock,
   input  wire                 wr_en,
   input  wire [ADDR_W-1:0]    wr_addr,
   input  ajm_pkg::entry_type  wr_data,
   input  wire [ADDR_W-1:0]    rd_addr,
   output ajm_pkg::entry_type  rd_data
);

   ajm_pkg::entry_type mem_ff [DEPTH];
   ajm_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/adc_jitter_min_max_monitor.sv
`default_nettype none

`include "adc_jitter_min_max_monitor_assert.svh"

// Jitter monitor for scanned 12-bit converter channels. An item is taken at
// a clock edge with start high and busy low; results appear on rsp_item for
// one cycle with rsp_strobe high and cannot be held off, so the receiver must
// take every strobed cycle. A sample reads its channel entry from the min/max
// memory, then writes it back (the controller result, if enabled, strobes in
// the cycle after that). A tick that does not reach the period only advances
// the tick counter. A tick that reaches it reads the GROUP_SIZE entries of the
// watched group, one per cycle, then sweeps the memory back to its cleared
// value at one entry per cycle, with busy high throughout; when no group is
// selected it only sweeps. Each report line passes the memory's read register
// and then the result register before it is on rsp_item, so the last lines
// of a report come out while the sweep has begun. After reset the same sweep
// runs before the first item is taken; configuration writes are taken at any
// time and need no handshake.
module adc_jitter_min_max_monitor #(
   parameter int NUM_MODULES     = ajm_pkg::NUM_MODULES_DEF,
   parameter int PINS_PER_MODULE = ajm_pkg::PINS_PER_MODULE_DEF,
   parameter int GROUP_SIZE      = ajm_pkg::GROUP_SIZE_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // command channel
   input  wire                             start,
   output logic                            busy,
   input  ajm_pkg::req_type                req_item,
   // results
   output logic                            rsp_strobe,
   output ajm_pkg::rsp_type                rsp_item,
   // register writes
   input  wire                             csr_we,
   input  ajm_pkg::csr_index_type          csr_index,
   input  wire [ajm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH  = NUM_MODULES * PINS_PER_MODULE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int GRP_W  = $clog2(GROUP_SIZE);

   typedef enum logic [1:0] {
      ST_CLEAR,   // sweep every entry back to its cleared value
      ST_IDLE,
      ST_UPDATE,  // read data for a sample is back, write it
      ST_REPORT   // issue reads for the watched group
   } state_type;

   state_type state_ff;

   // configuration
   logic                             send_ctrl_ff;
   logic [1:0]                       watch_mod_ff;
   logic [3:0]                       watch_grp_ff;
   logic [ajm_pkg::PERIOD_W-1:0]     period_ff;
   logic [ajm_pkg::PERIOD_W-1:0]     tick_ff;

   // sweep counter
   logic [ADDR_W-1:0]                clr_idx_ff;

   // sample in flight
   logic                             upd_ok_ff;
   logic [ADDR_W-1:0]                upd_addr_ff;
   logic [ajm_pkg::PIN_W-1:0]        upd_pin_ff;
   logic [ajm_pkg::SAMPLE_W-1:0]     upd_val_ff;

   // report read issue
   logic [ADDR_W-1:0]                rpt_addr_ff;
   logic [ajm_pkg::PIN_W-1:0]        rpt_pin_ff;
   logic [GRP_W-1:0]                 rpt_cnt_ff;

   // report read return
   logic                             rd_vld_ff;
   logic [ajm_pkg::PIN_W-1:0]        rd_pin_ff;
   logic                             rd_last_ff;

   logic                             rsp_strobe_ff;
   ajm_pkg::rsp_type                 rsp_item_ff;

   // memory port
   logic                             mem_we;
   logic [ADDR_W-1:0]                mem_waddr;
   logic [ADDR_W-1:0]                mem_raddr;
   ajm_pkg::entry_type               entry_in;
   ajm_pkg::entry_type               rd_entry;

   logic                             accept;
   logic                             smp_in_range;
   logic [ADDR_W-1:0]                smp_addr;
   logic [ajm_pkg::PERIOD_W-1:0]     tick_in;
   logic                             period_hit;
   logic                             sel_ok;
   logic [ADDR_W-1:0]                sel_base;
   logic [ajm_pkg::PIN_W-1:0]        sel_pin0;
   ajm_pkg::entry_type               merged;
   ajm_pkg::rsp_type                 rsp_item_in;
   logic                             rsp_strobe_in;
   logic                             lo_le_hi;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // sample address: module * PINS_PER_MODULE + pin
   assign smp_in_range = (int'(req_item.module_index) < NUM_MODULES)
                      && (int'(req_item.pin_index) < PINS_PER_MODULE);
   assign smp_addr = smp_in_range
      ? ADDR_W'(int'(req_item.module_index) * PINS_PER_MODULE + int'(req_item.pin_index))
      : '0;

   // period counter: wraps at 16 bits, a period of zero always hits
   assign tick_in    = tick_ff + ajm_pkg::PERIOD_W'(1);
   assign period_hit = !(tick_in < period_ff);

   // watched group selection, 1-based
   assign sel_ok = (watch_mod_ff != '0) && (watch_grp_ff != '0)
                && (int'(watch_mod_ff) <= NUM_MODULES)
                && (int'(watch_grp_ff) * GROUP_SIZE <= PINS_PER_MODULE);
   assign sel_base = ADDR_W'((int'(watch_mod_ff) - 1) * PINS_PER_MODULE
                           + (int'(watch_grp_ff) - 1) * GROUP_SIZE);
   assign sel_pin0 = ajm_pkg::PIN_W'((int'(watch_grp_ff) - 1) * GROUP_SIZE);

   // read-modify-write of one channel entry
   always_comb begin
      merged = rd_entry;
      if (rd_entry.min_none || (upd_val_ff < rd_entry.min_value)) begin
         merged.min_none  = 1'b0;
         merged.min_value = upd_val_ff;
      end
      if (upd_val_ff > rd_entry.max_value) begin
         merged.max_value = upd_val_ff;
      end
   end

   always_comb begin
      mem_raddr = (state_ff == ST_REPORT) ? rpt_addr_ff : smp_addr;
      mem_we    = 1'b0;
      mem_waddr = upd_addr_ff;
      entry_in  = merged;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            entry_in  = ajm_pkg::ENTRY_CLEAR;
         end
         ST_UPDATE: begin
            mem_we = upd_ok_ff;
         end
         ST_IDLE, ST_REPORT: begin
            mem_we = 1'b0;
         end
      endcase
   end

   ajm_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (entry_in),
      .rd_addr (mem_raddr),
      .rd_data (rd_entry)
   );

   // result formatting: report line when a report read returns, else controller
   assign lo_le_hi = !rd_entry.min_none && (rd_entry.min_value <= rd_entry.max_value);

   always_comb begin
      rsp_item_in = '0;
      if (rd_vld_ff) begin
         rsp_item_in.result_kind    = ajm_pkg::KIND_REPORT;
         rsp_item_in.report_pin     = rd_pin_ff;
         rsp_item_in.min_value      = rd_entry.min_none ? '0 : rd_entry.min_value;
         rsp_item_in.max_value      = rd_entry.max_value;
         rsp_item_in.spread         = lo_le_hi ? (rd_entry.max_value - rd_entry.min_value)
                                               : '0;
         rsp_item_in.min_seen       = !rd_entry.min_none;
         rsp_item_in.max_seen       = (rd_entry.max_value != '0);
         rsp_item_in.spread_valid   = lo_le_hi;
         rsp_item_in.last_of_report = rd_last_ff;
      end else begin
         rsp_item_in.result_kind       = ajm_pkg::KIND_CTRL;
         rsp_item_in.controller_number = {1'b0, upd_pin_ff} + ajm_pkg::CTRL_OFFSET;
         rsp_item_in.controller_value  =
            upd_val_ff[ajm_pkg::SAMPLE_W-1 -: ajm_pkg::SAMPLE_W - ajm_pkg::CTRL_SHIFT];
      end
   end

   assign rsp_strobe_in = rd_vld_ff || ((state_ff == ST_UPDATE) && upd_ok_ff && send_ctrl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         send_ctrl_ff  <= ajm_pkg::SEND_CTRL_RST;
         watch_mod_ff  <= ajm_pkg::WATCH_MOD_RST;
         watch_grp_ff  <= ajm_pkg::WATCH_GRP_RST;
         period_ff     <= ajm_pkg::PERIOD_RST;
         tick_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ajm_pkg::CSR_SEND_CTRL: send_ctrl_ff <= csr_wdata[0];
               ajm_pkg::CSR_WATCH_MOD: watch_mod_ff <= csr_wdata[1:0];
               ajm_pkg::CSR_WATCH_GRP: watch_grp_ff <= csr_wdata[3:0];
               ajm_pkg::CSR_PERIOD:    period_ff    <= csr_wdata[ajm_pkg::PERIOD_W-1:0];
            endcase
         end

         rsp_strobe_ff <= rsp_strobe_in;
         rsp_item_ff   <= rsp_item_in;
         rd_vld_ff     <= (state_ff == ST_REPORT);
         rd_pin_ff     <= rpt_pin_ff;
         rd_last_ff    <= (rpt_cnt_ff == GRP_W'(GROUP_SIZE - 1));

         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + ADDR_W'(1);
               if (clr_idx_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_item.command == ajm_pkg::CMD_SAMPLE) begin
                     // memory read issued this edge at smp_addr
                     upd_ok_ff   <= smp_in_range;
                     upd_addr_ff <= smp_addr;
                     upd_pin_ff  <= req_item.pin_index;
                     upd_val_ff  <= req_item.sample_value;
                     state_ff    <= ST_UPDATE;
                  end else if (!period_hit) begin
                     tick_ff <= tick_in;
                  end else begin
                     tick_ff    <= '0;
                     clr_idx_ff <= '0;
                     if (sel_ok) begin
                        rpt_addr_ff <= sel_base;
                        rpt_pin_ff  <= sel_pin0;
                        rpt_cnt_ff  <= '0;
                        state_ff    <= ST_REPORT;
                     end else begin
                        state_ff <= ST_CLEAR;
                     end
                  end
               end
            end
            ST_UPDATE: begin
               state_ff <= ST_IDLE;
            end
            ST_REPORT: begin
               rpt_addr_ff <= rpt_addr_ff + ADDR_W'(1);
               rpt_pin_ff  <= rpt_pin_ff + ajm_pkg::PIN_W'(1);
               rpt_cnt_ff  <= rpt_cnt_ff + GRP_W'(1);
               if (rpt_cnt_ff == GRP_W'(GROUP_SIZE - 1)) begin
                  // last read is already issued; sweep may start overwriting
                  clr_idx_ff <= '0;
                  state_ff   <= ST_CLEAR;
               end
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // a sample must hold busy for its write-back, else a following item could
   // read the entry before it is written
   `AJM_ASSERT_NEXT(a_sample_blocks, clock, reset,
      accept && (req_item.command == ajm_pkg::CMD_SAMPLE), busy,
      "sample accepted without interlock")
   // report lines only come out while the group read or sweep runs
   `AJM_ASSERT_IMPLY(a_report_while_busy, clock, reset,
      rsp_strobe && (rsp_item.result_kind == ajm_pkg::KIND_REPORT), busy,
      "report line outside report run")
   // the last report line closes its run
   `AJM_ASSERT_NEXT(a_last_closes_run, clock, reset,
      rsp_strobe && rsp_item.last_of_report, !rsp_strobe,
      "result directly after last report line")
   // the sweep never leaves the memory
   `AJM_ASSERT_IMPLY(a_clear_in_range, clock, reset,
      state_ff == ST_CLEAR, int'(clr_idx_ff) < DEPTH,
      "clear index beyond memory depth")

endmodule

`default_nettype wire
